// ----- hw/rtl/sfgr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfgr_pkg
// Shared widths, constants and controller/datapath interface types for the
// stereo fade gain ramp.
// ----------------------------------------------------------------------------
package sfgr_pkg;

    // Field widths
    localparam int SAMPLE_BITS     = 24;
    localparam int RAMP_COUNT_BITS = 24;
    localparam int GAIN_FRAC_BITS  = 24;

    // Derived widths: applied gain Q1.F, accumulator Q1.2F, signed step
    localparam int GAIN_W    = GAIN_FRAC_BITS + 1;
    localparam int ACC_W     = 2 * GAIN_FRAC_BITS + 1;
    localparam int STEP_W    = ACC_W + 1;
    localparam int MUL_W     = ((SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W) + 1;
    localparam int DIV_CNT_W = $clog2(ACC_W + 1);

    // Accumulator value of unity gain
    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1) << (2 * GAIN_FRAC_BITS);

    // Shared multiplier operand selection
    typedef enum logic [1:0] {
        MUL_GG    = 2'd0,
        MUL_G2    = 2'd1,
        MUL_LEFT  = 2'd2,
        MUL_RIGHT = 2'd3
    } t_mul_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     frame_start;
        logic     g4_load;
        logic     left_load;
        logic     emit;
        logic     ramp_start;
        logic     div_step;
        logic     div_finish;
        t_mul_sel mul_sel;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic len_zero;
        logic div_done;
    } t_dp_status;

endpackage

// ----- hw/rtl/stereo_fade_gain_ramp_top.sv -----
// ----------------------------------------------------------------------------
// stereo_fade_gain_ramp_top
// Stereo fade stage: linear gain ramp with a quartic volume curve.
// ----------------------------------------------------------------------------
// Frame: steps g^2, g^4, left, right on the single shared multiplier; no new
//   item is taken until the last one is emitted.
// Ramp command: a zero length sets the gain directly, else the bit-serial
//   step divider runs (one quotient bit per cycle); no result.
// Reset (synchronous, active low) sets silent gain, no ramp, no result.
// ----------------------------------------------------------------------------
module stereo_fade_gain_ramp_top
    import sfgr_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic                              i_target_play,
    input  logic        [RAMP_COUNT_BITS-1:0] i_ramp_frames,
    input  logic signed [SAMPLE_BITS-1:0]     i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_right_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_left_out,
    output logic signed [SAMPLE_BITS-1:0]     o_right_out,
    output logic        [GAIN_W-1:0]          o_gain_level,
    output logic                              o_ramping
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer
    sfgr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Gain state and arithmetic
    sfgr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_target_play  (i_target_play),
        .i_ramp_frames  (i_ramp_frames),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_gain_level   (o_gain_level),
        .o_ramping      (o_ramping)
    );

endmodule

// ----- hw/rtl/sfgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfgr_ctrl
// Sequencer for the fade gain stage: frame multiply steps, ramp step division
// and the output register handshake.
// ----------------------------------------------------------------------------
module sfgr_ctrl
    import sfgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_G4   = 5'b00010,
        ST_LEFT = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_DIV  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_accept;
    logic   out_free;

    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Sequence the work of one item
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.mul_sel = MUL_GG;
                if (in_accept) begin
                    if (i_mode) begin
                        o_cmd.ramp_start = 1'b1;
                        n_state = i_status.len_zero ? ST_IDLE : ST_DIV;
                    end else begin
                        o_cmd.frame_start = 1'b1;
                        n_state = ST_G4;
                    end
                end
            end
            ST_G4: begin
                o_cmd.mul_sel = MUL_G2;
                o_cmd.g4_load = 1'b1;
                n_state = ST_LEFT;
            end
            ST_LEFT: begin
                o_cmd.mul_sel   = MUL_LEFT;
                o_cmd.left_load = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.mul_sel = MUL_RIGHT;
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                o_cmd.mul_sel = MUL_GG;
                if (i_status.div_done) begin
                    o_cmd.div_finish = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until it is transferred
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A new result only appears from the emit step
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_EMIT)
        else $error("result valid rose outside the emit step");

    // Never overwrite a result still waiting to be transferred
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.emit)
        else $error("emit while the output register is stalled");

    // A frame always reaches the emit step by way of the g^4 and left steps
    a_frame_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_mode) |-> ##3 (r_state == ST_EMIT))
        else $error("frame did not reach the emit step in sequence");

endmodule

// ----- hw/rtl/sfgr_dpath.sv -----
// ----------------------------------------------------------------------------
// sfgr_dpath
// Gain state, shared multiplier for the quartic curve and sample scaling,
// bit-serial divider for the ramp step, and the result register.
// ----------------------------------------------------------------------------
module sfgr_dpath
    import sfgr_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic                          i_target_play,
    input  logic        [RAMP_COUNT_BITS-1:0] i_ramp_frames,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    output logic        [GAIN_W-1:0]      o_gain_level,
    output logic                          o_ramping
);

    // Gain state
    logic [ACC_W-1:0]           r_accum, n_accum;
    logic                       r_target_full, n_target_full;
    logic [STEP_W-1:0]          r_step, n_step;
    logic [RAMP_COUNT_BITS-1:0] r_frames_left, n_frames_left;

    // Divider
    logic [RAMP_COUNT_BITS-1:0] r_len;
    logic [RAMP_COUNT_BITS-1:0] r_rem;
    logic [ACC_W-1:0]           r_quo;
    logic                       r_div_neg;
    logic [DIV_CNT_W-1:0]       r_div_cnt;

    // Frame work registers
    logic signed [SAMPLE_BITS-1:0] r_left_in, r_right_in;
    logic [GAIN_W-1:0]             r_g2, r_g4;
    logic signed [SAMPLE_BITS-1:0] r_left_res;

    // Result register
    logic signed [SAMPLE_BITS-1:0] r_out_left, r_out_right;
    logic [GAIN_W-1:0]             r_out_gain;
    logic                          r_out_ramping;

    logic [GAIN_W-1:0]             gain;
    logic signed [MUL_W-1:0]       mul_a, mul_b;
    logic signed [2*MUL_W-1:0]     mul_p;
    logic [RAMP_COUNT_BITS-1:0]    even_len;
    logic [ACC_W-1:0]              diff_mag;
    logic [RAMP_COUNT_BITS:0]      rem_sh;
    logic                          rem_ge;
    logic [STEP_W:0]               sum;
    logic [ACC_W-1:0]              sum_clamped;
    logic                          active;
    logic [RAMP_COUNT_BITS-1:0]    frames_dec;

    assign gain   = r_accum[ACC_W-1:GAIN_FRAC_BITS];
    assign active = (r_frames_left != '0);

    // Select operands for the shared multiplier
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_GG: begin
                mul_a = signed'({{(MUL_W-GAIN_W){1'b0}}, gain});
                mul_b = signed'({{(MUL_W-GAIN_W){1'b0}}, gain});
            end
            MUL_G2: begin
                mul_a = signed'({{(MUL_W-GAIN_W){1'b0}}, r_g2});
                mul_b = signed'({{(MUL_W-GAIN_W){1'b0}}, r_g2});
            end
            MUL_LEFT: begin
                mul_a = signed'({{(MUL_W-SAMPLE_BITS){r_left_in[SAMPLE_BITS-1]}}, r_left_in});
                mul_b = signed'({{(MUL_W-GAIN_W){1'b0}}, r_g4});
            end
            default: begin
                mul_a = signed'({{(MUL_W-SAMPLE_BITS){r_right_in[SAMPLE_BITS-1]}},
                                 r_right_in});
                mul_b = signed'({{(MUL_W-GAIN_W){1'b0}}, r_g4});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Ramp length rounded down to even, and distance to the new target
    assign even_len = {i_ramp_frames[RAMP_COUNT_BITS-1:1], 1'b0};
    assign diff_mag = i_target_play ? (ACC_ONE - r_accum) : r_accum;

    assign o_status.len_zero = (even_len == '0);
    assign o_status.div_done = (r_div_cnt == '0);

    // One quotient bit per step
    assign rem_sh = {r_rem, r_quo[ACC_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_len});

    // Advance the gain by the step and hold it within silence and unity
    assign sum = {2'b00, r_accum} + {r_step[STEP_W-1], r_step};
    always_comb begin
        if (sum[STEP_W]) begin
            sum_clamped = '0;
        end else if (sum > (STEP_W+1)'(ACC_ONE)) begin
            sum_clamped = ACC_ONE;
        end else begin
            sum_clamped = sum[ACC_W-1:0];
        end
    end
    assign frames_dec = r_frames_left - RAMP_COUNT_BITS'(1);

    // Next gain state
    always_comb begin
        n_accum       = r_accum;
        n_target_full = r_target_full;
        n_step        = r_step;
        n_frames_left = r_frames_left;
        priority if (i_cmd.ramp_start) begin
            n_target_full = i_target_play;
            if (even_len == '0) begin
                n_accum       = i_target_play ? ACC_ONE : '0;
                n_step        = '0;
                n_frames_left = '0;
            end
        end else if (i_cmd.div_finish) begin
            n_step        = r_div_neg ? -{1'b0, r_quo} : {1'b0, r_quo};
            n_frames_left = r_len;
        end else if (i_cmd.emit && active) begin
            n_frames_left = frames_dec;
            if (frames_dec == '0) begin
                n_accum = r_target_full ? ACC_ONE : '0;
                n_step  = '0;
            end else begin
                n_accum = sum_clamped;
            end
        end else begin
            // Hold the gain between steps
            n_accum = r_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum       <= '0;
            r_target_full <= 1'b0;
            r_step        <= '0;
            r_frames_left <= '0;
            r_div_cnt     <= '0;
        end else begin
            r_accum       <= n_accum;
            r_target_full <= n_target_full;
            r_step        <= n_step;
            r_frames_left <= n_frames_left;
            if (i_cmd.ramp_start) begin
                r_div_cnt <= DIV_CNT_W'(ACC_W);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
        end
    end

    // Divider and frame work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ramp_start) begin
            r_len     <= even_len;
            r_rem     <= '0;
            r_quo     <= diff_mag;
            r_div_neg <= !i_target_play;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? RAMP_COUNT_BITS'(rem_sh - {1'b0, r_len})
                            : rem_sh[RAMP_COUNT_BITS-1:0];
            r_quo <= {r_quo[ACC_W-2:0], rem_ge};
        end
        if (i_cmd.frame_start) begin
            r_left_in  <= i_left_sample;
            r_right_in <= i_right_sample;
            r_g2       <= mul_p[GAIN_FRAC_BITS +: GAIN_W];
        end
        if (i_cmd.g4_load) begin
            r_g4 <= mul_p[GAIN_FRAC_BITS +: GAIN_W];
        end
        if (i_cmd.left_load) begin
            r_left_res <= mul_p[GAIN_FRAC_BITS +: SAMPLE_BITS];
        end
        if (i_cmd.emit) begin
            r_out_left    <= r_left_res;
            r_out_right   <= mul_p[GAIN_FRAC_BITS +: SAMPLE_BITS];
            r_out_gain    <= gain;
            r_out_ramping <= active;
        end
    end

    assign o_left_out   = r_out_left;
    assign o_right_out  = r_out_right;
    assign o_gain_level = r_out_gain;
    assign o_ramping    = r_out_ramping;

    // Gain never leaves the range from silence to unity
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_accum <= ACC_ONE)
        else $error("gain accumulator above unity");

    // With no ramp counting down the step is cleared
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frames_left == '0) |-> (r_step == '0))
        else $error("step left over with no ramp active");

    // The remainder stays below the divisor while dividing
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step || i_cmd.div_finish) |-> (r_rem < r_len))
        else $error("divider remainder out of range");

endmodule
